### hdl/ovk_pkg.sv
// ----------------------------------------------------------------------------
// ovk_pkg - shared types and constants for the overlay colour/key pipeline
// Register indexes, source formats, key function codes, stage records and
// small helper functions used by the pipeline stages.
// ----------------------------------------------------------------------------
`default_nettype none

package ovk_pkg;

    // config register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_FORMAT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLOUR_CONTROL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_CONTROL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VKEY_COLOUR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VKEY_MASK = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GKEY_COLOUR = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GKEY_MASK = 3'd6;

    // key function codes; all others are never-true
    localparam logic [2:0] KEY_ALWAYS = 3'd1;
    localparam logic [2:0] KEY_MATCH = 3'd4;
    localparam logic [2:0] KEY_MISMATCH = 3'd5;

    // BT.601 coefficients and offsets
    localparam logic signed [19:0] K_Y = 20'sd298;
    localparam logic signed [19:0] K_RV = 20'sd409;
    localparam logic signed [19:0] K_GU = 20'sd100;
    localparam logic signed [19:0] K_GV = 20'sd208;
    localparam logic signed [19:0] K_BU = 20'sd516;
    localparam logic signed [9:0] Y_OFFSET = 10'sd16;
    localparam logic signed [20:0] ROUND_HALF = 21'sd128;

    typedef enum logic [1:0] {
        FMT_RGB555,
        FMT_RGB565,
        FMT_RGB32,
        FMT_YCBCR
    } t_fmt;

    typedef struct packed {
        t_fmt        fmt;
        logic [6:0]  bright;
        logic [4:0]  sat_u;
        logic [4:0]  sat_v;
        logic [2:0]  vkey_fn;
        logic [2:0]  gkey_fn;
        logic        key_and;
        logic [31:0] vkey_colour;
        logic [31:0] vkey_mask;
        logic [31:0] gkey_colour;
        logic [31:0] gkey_mask;
    } t_cfg;

    // stage 1 -> stage 2
    typedef struct packed {
        logic               is_yuv;
        logic [23:0]        rgb_direct;
        logic               show;
        logic [7:0]         y;
        logic signed [13:0] u_prod;
        logic signed [13:0] v_prod;
    } t_s1;

    // stage 2 -> stage 3
    typedef struct packed {
        logic               is_yuv;
        logic [23:0]        rgb_direct;
        logic               show;
        logic signed [19:0] p_y;
        logic signed [19:0] p_rv;
        logic signed [19:0] p_gu;
        logic signed [19:0] p_gv;
        logic signed [19:0] p_bu;
    } t_s2;

    function automatic logic key_fn(input logic [2:0] code, input logic match);
        logic res;
        unique case (code)
            KEY_ALWAYS:   res = 1'b1;
            KEY_MATCH:    res = match;
            KEY_MISMATCH: res = ~match;
            default:      res = 1'b0;
        endcase
        return res;
    endfunction

    // floor >>8 then clamp to 0..255
    function automatic logic [7:0] shr8_clamp(input logic signed [20:0] s);
        logic signed [12:0] t;
        logic [7:0] res;
        t = 13'(s >>> 8);
        if (t[12]) begin
            res = 8'd0;
        end else if (|t[11:8]) begin
            res = 8'hff;
        end else begin
            res = t[7:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### hdl/ovk_front.sv
// ----------------------------------------------------------------------------
// ovk_front - pipeline stage 1
// Format unpack, colour keys, luma brightness clamp and chroma saturation
// products; registered into the stage 1 record.
// ----------------------------------------------------------------------------
`default_nettype none

module ovk_front (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire ovk_pkg::t_cfg i_cfg,
    input  wire logic [31:0]   i_source_pixel,
    input  wire logic [23:0]   i_frame_pixel,
    output ovk_pkg::t_s1       o_s1
);
    import ovk_pkg::*;

    t_s1 r_s1;
    t_s1 n_s1;

    logic [31:0]        px;
    logic [23:0]        rgb_d;
    logic               vmatch;
    logic               gmatch;
    logic               vsel;
    logic               gsel;
    logic signed [9:0]  y_sum;
    logic signed [7:0]  u_c;
    logic signed [7:0]  v_c;

    always_comb begin
        unique case (i_cfg.fmt)
            FMT_RGB555: begin
                px = {16'd0, i_source_pixel[15:0]};
                rgb_d = {px[14:10], px[14:12], px[9:5], px[9:7], px[4:0], px[4:2]};
            end
            FMT_RGB565: begin
                px = {16'd0, i_source_pixel[15:0]};
                rgb_d = {px[15:11], px[15:13], px[10:5], px[10:9], px[4:0], px[4:2]};
            end
            FMT_RGB32: begin
                px = i_source_pixel;
                rgb_d = i_source_pixel[23:0];
            end
            default: begin
                px = {8'd0, i_source_pixel[23:0]};
                rgb_d = i_source_pixel[23:0];
            end
        endcase

        vmatch = ((px ^ i_cfg.vkey_colour) & i_cfg.vkey_mask) == 32'd0;
        gmatch = (({8'd0, i_frame_pixel} ^ i_cfg.gkey_colour) & i_cfg.gkey_mask) == 32'd0;
        vsel = key_fn(i_cfg.vkey_fn, vmatch);
        gsel = key_fn(i_cfg.gkey_fn, gmatch);

        // luma plus signed brightness
        y_sum = $signed({2'b00, px[7:0]}) + $signed({{3{i_cfg.bright[6]}}, i_cfg.bright});

        // chroma minus 128
        u_c = $signed({~px[15], px[14:8]});
        v_c = $signed({~px[23], px[22:16]});

        n_s1.is_yuv = (i_cfg.fmt == FMT_YCBCR);
        n_s1.rgb_direct = rgb_d;
        n_s1.show = i_cfg.key_and ? (gsel & vsel) : (gsel | vsel);
        if (y_sum[9]) begin
            n_s1.y = 8'd0;
        end else if (y_sum[8]) begin
            n_s1.y = 8'hff;
        end else begin
            n_s1.y = y_sum[7:0];
        end
        n_s1.u_prod = 14'(u_c * $signed({1'b0, i_cfg.sat_u}));
        n_s1.v_prod = 14'(v_c * $signed({1'b0, i_cfg.sat_v}));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1 = r_s1;

endmodule

`default_nettype wire

### hdl/ovk_csc.sv
// ----------------------------------------------------------------------------
// ovk_csc - pipeline stages 2 and 3
// BT.601 coefficient products, then sums, floor shift, clamp and the
// output word register.
// ----------------------------------------------------------------------------
`default_nettype none

module ovk_csc (
    input  wire logic         i_clk,
    input  wire logic         i_en2,
    input  wire logic         i_en3,
    input  wire ovk_pkg::t_s1 i_s1,
    output logic [23:0]       o_rgb_out,
    output logic              o_show_graphics
);
    import ovk_pkg::*;

    t_s2 r_s2;
    t_s2 n_s2;
    logic [23:0] r_rgb;
    logic [23:0] n_rgb;
    logic        r_show;

    logic signed [9:0]  d;
    logic signed [9:0]  e;
    logic signed [9:0]  c;
    logic signed [19:0] d_x;
    logic signed [19:0] e_x;
    logic signed [19:0] c_x;
    logic signed [20:0] s_r;
    logic signed [20:0] s_g;
    logic signed [20:0] s_b;

    // stage 2: chroma floor >>4, coefficient products
    always_comb begin
        d = i_s1.u_prod[13:4];
        e = i_s1.v_prod[13:4];
        c = $signed({2'b00, i_s1.y}) - Y_OFFSET;
        d_x = {{10{d[9]}}, d};
        e_x = {{10{e[9]}}, e};
        c_x = {{10{c[9]}}, c};
        n_s2.is_yuv = i_s1.is_yuv;
        n_s2.rgb_direct = i_s1.rgb_direct;
        n_s2.show = i_s1.show;
        n_s2.p_y = 20'(K_Y * c_x);
        n_s2.p_rv = 20'(K_RV * e_x);
        n_s2.p_gu = 20'(K_GU * d_x);
        n_s2.p_gv = 20'(K_GV * e_x);
        n_s2.p_bu = 20'(K_BU * d_x);
    end

    always_ff @(posedge i_clk) begin
        if (i_en2) begin
            r_s2 <= n_s2;
        end
    end

    // stage 3: sums, rounding, clamp
    always_comb begin
        s_r = 21'(r_s2.p_y) + 21'(r_s2.p_rv) + ROUND_HALF;
        s_g = 21'(r_s2.p_y) - 21'(r_s2.p_gu) - 21'(r_s2.p_gv) + ROUND_HALF;
        s_b = 21'(r_s2.p_y) + 21'(r_s2.p_bu) + ROUND_HALF;
        if (r_s2.is_yuv) begin
            n_rgb = {shr8_clamp(s_r), shr8_clamp(s_g), shr8_clamp(s_b)};
        end else begin
            n_rgb = r_s2.rgb_direct;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en3) begin
            r_rgb <= n_rgb;
            r_show <= r_s2.show;
        end
    end

    assign o_rgb_out = r_rgb;
    assign o_show_graphics = r_show;

endmodule

`default_nettype wire

### hdl/overlay_pixel_colour_and_key_top.sv
// ----------------------------------------------------------------------------
// overlay_pixel_colour_and_key_top - overlay pixel colour conversion and keys
// Takes a source overlay pixel and the framebuffer pixel under it, returns
// the 24-bit overlay colour and whether the graphics pixel is kept.
//
// Usage:
//  - Input channel (i_valid / o_ready) carries one word per overlay pixel:
//    i_source_pixel (RGB555, RGB565, RGB32 or packed Cr/Cb/Y) and
//    i_frame_pixel. Output channel (o_valid / i_ready) returns o_rgb_out and
//    o_show_graphics, one word per input word, in order.
//  - Three register stages: unpack/keys/chroma scale, BT.601 products,
//    sums/clamp into the output register. o_valid rises once an accepted
//    word has reached the output register; throughput is one word per
//    cycle while the receiver holds i_ready high.
//  - Each stage advances when it is empty or the stage after it advances,
//    so bubbles are squeezed out and a new word is taken while a finished
//    word waits at the output. A receiver stall holds every full stage; no
//    word is lost or repeated.
//  - Configuration: i_cfg_wr_en writes i_cfg_wdata to register i_cfg_index
//    (0 format, 1 colour control, 2 key control, 3..6 key colours/masks);
//    write only while the pipeline is empty.
//  - Reset (synchronous, active low) clears the configuration and stage
//    valid registers and empties the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module overlay_pixel_colour_and_key_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [ovk_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [ovk_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic [31:0]                       i_source_pixel,
    input  wire logic [23:0]                       i_frame_pixel,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic [23:0]                            o_rgb_out,
    output logic                                   o_show_graphics
);
    import ovk_pkg::*;

    // configuration registers
    t_cfg r_cfg;

    // stage valid bits
    logic r_v1;
    logic r_v2;
    logic r_v3;

    // stage advance enables
    logic en1;
    logic en2;
    logic en3;

    t_s1 s1;

    assign en3 = ~r_v3 | i_ready;
    assign en2 = ~r_v2 | en3;
    assign en1 = ~r_v1 | en2;
    assign o_ready = en1;
    assign o_valid = r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_SOURCE_FORMAT: begin
                    r_cfg.fmt <= t_fmt'(i_cfg_wdata[1:0]);
                end
                REG_COLOUR_CONTROL: begin
                    r_cfg.bright <= i_cfg_wdata[6:0];
                    r_cfg.sat_u <= i_cfg_wdata[12:8];
                    r_cfg.sat_v <= i_cfg_wdata[20:16];
                end
                REG_KEY_CONTROL: begin
                    r_cfg.vkey_fn <= i_cfg_wdata[2:0];
                    r_cfg.gkey_fn <= i_cfg_wdata[6:4];
                    r_cfg.key_and <= i_cfg_wdata[8];
                end
                REG_VKEY_COLOUR: r_cfg.vkey_colour <= i_cfg_wdata;
                REG_VKEY_MASK:   r_cfg.vkey_mask <= i_cfg_wdata;
                REG_GKEY_COLOUR: r_cfg.gkey_colour <= i_cfg_wdata;
                REG_GKEY_MASK:   r_cfg.gkey_mask <= i_cfg_wdata;
                default: ; // unmapped index: dropped
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    ovk_front u_front (
        .i_clk          (i_clk),
        .i_en           (en1),
        .i_cfg          (r_cfg),
        .i_source_pixel (i_source_pixel),
        .i_frame_pixel  (i_frame_pixel),
        .o_s1           (s1)
    );

    ovk_csc u_csc (
        .i_clk           (i_clk),
        .i_en2           (en2),
        .i_en3           (en3),
        .i_s1            (s1),
        .o_rgb_out       (o_rgb_out),
        .o_show_graphics (o_show_graphics)
    );

endmodule

`default_nettype wire
